// ----- hdl/srdm_pkg.sv -----
// shared types, constants and functions of the skin ratio drowsiness monitor
`timescale 1ns / 1ps
package srdm_pkg;

  localparam int unsigned MaxFaces         = 128;
  localparam int unsigned SlotW            = $clog2(MaxFaces);
  localparam int unsigned CountW           = 16;
  localparam int unsigned DcntW            = 4;
  localparam int unsigned XW               = 12;
  localparam int unsigned HueW             = 8;
  localparam int unsigned SatW             = 8;
  localparam int unsigned PctW             = 7;
  localparam int unsigned ZoneW            = 2;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 12;
  localparam int unsigned PixelsPerPercent = 400;
  localparam int unsigned HueWrap          = 180;

  // reciprocal of three for operands below 2^13, exact after the shift
  localparam int unsigned RecipThree       = 10923;
  localparam int unsigned RecipShift       = 15;
  localparam int unsigned RecipProdW       = 27;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [DcntW-1:0]  DcntMax  = {DcntW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_SAT_THRESHOLD = 3'd1,
    CFG_HUE_REF       = 3'd2,
    CFG_HUE_TOL       = 3'd3,
    CFG_LOW_SKIN_PCT  = 3'd4,
    CFG_FRAME_LIMIT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [ZoneW-1:0] {
    ZONE_NONE   = 2'd0,
    ZONE_LEFT   = 2'd1,
    ZONE_MIDDLE = 2'd2,
    ZONE_RIGHT  = 2'd3
  } zone_e;

  // region end handed from the pixel stage to the verdict stage
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic [XW-1:0]     left;
  } region_t;

  // settings derived from the configuration registers
  typedef struct packed {
    logic [CountW-1:0] skin_limit;
    logic [XW-1:0]     third;
    logic [XW-1:0]     two_third;
    logic [DcntW-1:0]  frame_limit;
  } verdict_cfg_t;

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  // hue within tolerance of the reference, also across the wrap at 180
  function automatic logic hue_close(input logic [HueW-1:0] h,
                                     input logic [HueW-1:0] ref_h,
                                     input logic [HueW-1:0] tol);
    logic signed [9:0] d;
    logic [9:0]        t;
    d = $signed({2'b00, h}) - $signed({2'b00, ref_h});
    t = {2'b00, tol};
    hue_close = (abs10(d) < t)
             || (abs10(d + 10'sd180) < t)
             || (abs10(d - 10'sd180) < t);
  endfunction

endpackage

// ----- hdl/srdm_pixel.sv -----
// pixel stage: skin test and the running skin tally of the current region
`timescale 1ns / 1ps
module srdm_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [srdm_pkg::SlotW-1:0]    face_slot_i,
  input  logic [srdm_pkg::HueW-1:0]     hue_i,
  input  logic [srdm_pkg::SatW-1:0]     saturation_i,
  input  logic                          region_end_i,
  input  logic [srdm_pkg::XW-1:0]       face_left_i,
  input  logic [srdm_pkg::SatW-1:0]     sat_threshold_i,
  input  logic [srdm_pkg::HueW-1:0]     hue_ref_i,
  input  logic [srdm_pkg::HueW-1:0]     hue_tol_i,
  output logic                          end_o,
  output srdm_pkg::region_t             region_o
);

  logic [srdm_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic                        skin_hit;

  assign skin_hit = (saturation_i > sat_threshold_i)
                 && srdm_pkg::hue_close(hue_i, hue_ref_i, hue_tol_i);

  always_comb begin
    count_inc = count_q;
    if (skin_hit && (count_q != srdm_pkg::CountMax)) begin
      count_inc = count_q + srdm_pkg::CountW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      count_d = region_end_i ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign end_o           = accept_i && region_end_i;
  assign region_o.slot   = face_slot_i;
  assign region_o.count  = count_inc;
  assign region_o.left   = face_left_i;

endmodule

// ----- hdl/srdm_counter_mem.sv -----
// drowsy counter memory with per-entry valid bits, registered read
`timescale 1ns / 1ps
module srdm_counter_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [srdm_pkg::SlotW-1:0]   rd_addr_i,
  output logic [srdm_pkg::DcntW-1:0]   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [srdm_pkg::SlotW-1:0]   wr_addr_i,
  input  logic [srdm_pkg::DcntW-1:0]   wr_data_i
);

  logic [srdm_pkg::DcntW-1:0] mem [srdm_pkg::MaxFaces];
  logic [srdm_pkg::MaxFaces-1:0] valid_q;
  logic [srdm_pkg::DcntW-1:0] rd_raw_q;
  logic                       rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never written entries read as zero
  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

// ----- hdl/srdm_verdict.sv -----
// verdict stage: counter update, alarm, zone and the result register
`timescale 1ns / 1ps
module srdm_verdict (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          end_i,
  input  srdm_pkg::region_t             region_i,
  output logic                          ready_o,
  input  srdm_pkg::verdict_cfg_t        cfg_i,
  output logic                          rd_en_o,
  output logic [srdm_pkg::SlotW-1:0]    rd_addr_o,
  input  logic [srdm_pkg::DcntW-1:0]    rd_data_i,
  output logic                          wr_en_o,
  output logic [srdm_pkg::SlotW-1:0]    wr_addr_o,
  output logic [srdm_pkg::DcntW-1:0]    wr_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srdm_pkg::SlotW-1:0]    out_face_slot_o,
  output logic [srdm_pkg::CountW-1:0]   skin_count_o,
  output logic                          alarm_o,
  output logic [srdm_pkg::ZoneW-1:0]    zone_o
);

  logic                       s1_valid_q, s1_valid_d;
  srdm_pkg::region_t          s1_q;
  logic                       advance;

  logic                       last_wr_valid_q;
  logic [srdm_pkg::SlotW-1:0] last_wr_addr_q;
  logic [srdm_pkg::DcntW-1:0] last_wr_data_q;

  logic                       out_valid_q, out_valid_d;
  logic [srdm_pkg::SlotW-1:0] out_slot_q;
  logic [srdm_pkg::CountW-1:0] out_count_q;
  logic                       out_alarm_q;
  srdm_pkg::zone_e            out_zone_q;

  logic [srdm_pkg::DcntW-1:0] cur_cnt, inc_cnt, new_cnt;
  logic                       alarm;
  srdm_pkg::zone_e            zone;

  // stage 1 moves on when the result register is free or being drained
  assign advance  = !out_valid_q || out_ready_i;
  assign ready_o  = !s1_valid_q || advance;
  assign rd_en_o  = end_i;
  assign rd_addr_o = region_i.slot;

  // most recent write equals the memory contents, so it can always be forwarded
  assign cur_cnt = (last_wr_valid_q && (last_wr_addr_q == s1_q.slot))
                 ? last_wr_data_q : rd_data_i;

  always_comb begin
    inc_cnt = cur_cnt;
    if (cur_cnt != srdm_pkg::DcntMax) begin
      inc_cnt = cur_cnt + srdm_pkg::DcntW'(1);
    end
  end

  always_comb begin
    alarm   = 1'b0;
    new_cnt = '0;
    if (s1_q.count < cfg_i.skin_limit) begin
      if (inc_cnt > cfg_i.frame_limit) begin
        alarm = 1'b1;
      end else begin
        new_cnt = inc_cnt;
      end
    end
  end

  always_comb begin
    priority if (!alarm) begin
      zone = srdm_pkg::ZONE_NONE;
    end else if (s1_q.left < cfg_i.third) begin
      zone = srdm_pkg::ZONE_LEFT;
    end else if (s1_q.left <= cfg_i.two_third) begin
      zone = srdm_pkg::ZONE_MIDDLE;
    end else begin
      zone = srdm_pkg::ZONE_RIGHT;
    end
  end

  assign wr_en_o   = s1_valid_q && advance;
  assign wr_addr_o = s1_q.slot;
  assign wr_data_o = new_cnt;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ready_o) begin
      s1_valid_d = end_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      last_wr_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_en_o) begin
        last_wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_i) begin
      s1_q <= region_i;
    end
    if (wr_en_o) begin
      last_wr_addr_q <= wr_addr_o;
      last_wr_data_q <= wr_data_o;
      out_slot_q     <= s1_q.slot;
      out_count_q    <= s1_q.count;
      out_alarm_q    <= alarm;
      out_zone_q     <= zone;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_face_slot_o = out_slot_q;
  assign skin_count_o    = out_count_q;
  assign alarm_o         = out_alarm_q;
  assign zone_o          = out_zone_q;

endmodule

// ----- hdl/skin_ratio_drowsiness_monitor_top.sv -----
// top level of the skin ratio drowsiness monitor
`timescale 1ns / 1ps
// usage
//   pixel channel: one HSV pixel beat per cycle on in_valid_i / in_ready_o with its
//   face slot, hue, saturation, region end flag and face x position
//   result channel: one beat on out_valid_o / out_ready_i for each region end pixel,
//   carrying the face slot, the region's skin count, the alarm flag and the zone
//   config channel: cfg_valid_i / cfg_ready_o with a register index and data, always
//   ready; write only while no pixels are in flight
// pipeline and throughput
//   a region end pixel is registered into the verdict stage together with its counter
//   memory read, and the verdict then goes into the result register
//   one pixel per cycle sustained while the receiver takes results; the one read port
//   and one write port of the counter memory serve one region end per cycle, with
//   back-to-back hits on the same face forwarded from the last write
// reset
//   config registers return to their defaults, the skin tally clears and every
//   drowsy counter reads zero at once through per-entry valid bits; no clearing pass
// stall
//   when the receiver holds off, the result register and the verdict stage fill
//   and in_ready_o drops until a beat leaves; no pixel is lost or repeated
module skin_ratio_drowsiness_monitor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srdm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [srdm_pkg::CfgDataW-1:0]       cfg_data_i,
  // pixel channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [srdm_pkg::SlotW-1:0]          face_slot_i,
  input  logic [srdm_pkg::HueW-1:0]           hue_i,
  input  logic [srdm_pkg::SatW-1:0]           saturation_i,
  input  logic                                region_end_i,
  input  logic [srdm_pkg::XW-1:0]             face_left_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [srdm_pkg::SlotW-1:0]          out_face_slot_o,
  output logic [srdm_pkg::CountW-1:0]         skin_count_o,
  output logic                                alarm_o,
  output logic [srdm_pkg::ZoneW-1:0]          zone_o
);

  // configuration registers
  logic [srdm_pkg::XW-1:0]    frame_width_q;
  logic [srdm_pkg::SatW-1:0]  sat_threshold_q;
  logic [srdm_pkg::HueW-1:0]  hue_ref_q;
  logic [srdm_pkg::HueW-1:0]  hue_tol_q;
  logic [srdm_pkg::PctW-1:0]  low_pct_q;
  logic [srdm_pkg::DcntW-1:0] frame_limit_q;
  logic                       cfg_we;

  // derived settings, registered off the config registers
  srdm_pkg::verdict_cfg_t     vcfg_q, vcfg_d;
  logic [srdm_pkg::RecipProdW-1:0] third_prod, two_third_prod;

  logic                       in_accept;
  logic                       end_beat;
  srdm_pkg::region_t          region;
  logic                       verdict_ready;

  logic                       rd_en, wr_en;
  logic [srdm_pkg::SlotW-1:0] rd_addr, wr_addr;
  logic [srdm_pkg::DcntW-1:0] rd_data, wr_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= srdm_pkg::XW'(640);
      sat_threshold_q <= srdm_pkg::SatW'(100);
      hue_ref_q       <= srdm_pkg::HueW'(15);
      hue_tol_q       <= srdm_pkg::HueW'(10);
      low_pct_q       <= srdm_pkg::PctW'(10);
      frame_limit_q   <= srdm_pkg::DcntW'(10);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        srdm_pkg::CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[srdm_pkg::XW-1:0];
        srdm_pkg::CFG_SAT_THRESHOLD: sat_threshold_q <= cfg_data_i[srdm_pkg::SatW-1:0];
        srdm_pkg::CFG_HUE_REF:       hue_ref_q       <= cfg_data_i[srdm_pkg::HueW-1:0];
        srdm_pkg::CFG_HUE_TOL:       hue_tol_q       <= cfg_data_i[srdm_pkg::HueW-1:0];
        srdm_pkg::CFG_LOW_SKIN_PCT:  low_pct_q       <= cfg_data_i[srdm_pkg::PctW-1:0];
        srdm_pkg::CFG_FRAME_LIMIT:   frame_limit_q   <= cfg_data_i[srdm_pkg::DcntW-1:0];
        default: ; // indexes past the list write nothing
      endcase
    end
  end

  // frame thirds by reciprocal multiply, exact for widths below 4096
  assign third_prod     = srdm_pkg::RecipProdW'(frame_width_q)
                        * srdm_pkg::RecipProdW'(srdm_pkg::RecipThree);
  assign two_third_prod = srdm_pkg::RecipProdW'({frame_width_q, 1'b0})
                        * srdm_pkg::RecipProdW'(srdm_pkg::RecipThree);

  always_comb begin
    vcfg_d.skin_limit  = srdm_pkg::CountW'(low_pct_q)
                       * srdm_pkg::CountW'(srdm_pkg::PixelsPerPercent);
    vcfg_d.third       = srdm_pkg::XW'(third_prod >> srdm_pkg::RecipShift);
    vcfg_d.two_third   = srdm_pkg::XW'(two_third_prod >> srdm_pkg::RecipShift);
    vcfg_d.frame_limit = frame_limit_q;
  end

  // settles after a config write in time for any pixel accepted after that write
  always_ff @(posedge clk_i) begin
    vcfg_q <= vcfg_d;
  end

  assign in_ready_o = verdict_ready;
  assign in_accept  = in_valid_i && in_ready_o;

  srdm_pixel u_pixel (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .face_slot_i     (face_slot_i),
    .hue_i           (hue_i),
    .saturation_i    (saturation_i),
    .region_end_i    (region_end_i),
    .face_left_i     (face_left_i),
    .sat_threshold_i (sat_threshold_q),
    .hue_ref_i       (hue_ref_q),
    .hue_tol_i       (hue_tol_q),
    .end_o           (end_beat),
    .region_o        (region)
  );

  srdm_counter_mem u_counter_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  srdm_verdict u_verdict (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .end_i           (end_beat),
    .region_i        (region),
    .ready_o         (verdict_ready),
    .cfg_i           (vcfg_q),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_face_slot_o (out_face_slot_o),
    .skin_count_o    (skin_count_o),
    .alarm_o         (alarm_o),
    .zone_o          (zone_o)
  );

endmodule
